FILE: rtl/gda_pkg.sv
// Shared types, constants and sequencer states for the Gower distance accumulator.
// Depends on nothing. Used by every module in rtl/.

package gda_pkg;

  localparam int FRAC_BITS = 16;                    // fraction bits of similarities and distance
  localparam int MAX_ATTRS = 64;                    // counted attributes per record pair
  localparam int VAL_W     = 32;                    // width of values and ranges
  localparam int CNT_W     = $clog2(MAX_ATTRS + 1);
  localparam int DIST_W    = FRAC_BITS + 1;
  localparam int SUM_W     = FRAC_BITS + CNT_W;
  localparam int STEP_W    = $clog2(SUM_W + 1);

  localparam logic [DIST_W-1:0] FX_ONE = DIST_W'(1) << FRAC_BITS;

  // Attribute kind codes; the fourth code is unused and is skipped.
  localparam logic [1:0] KIND_NUMERIC = 2'd0;
  localparam logic [1:0] KIND_NOMINAL = 2'd1;
  localparam logic [1:0] KIND_BINARY  = 2'd2;

  typedef struct packed {
    logic [1:0]              attr_kind;
    logic                    x_missing;
    logic                    y_missing;
    logic signed [VAL_W-1:0] x_value;
    logic signed [VAL_W-1:0] y_value;
    logic [VAL_W-1:0]        value_range;
    logic                    last_attr;
  } in_item_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic [CNT_W-1:0]  compared_count;
  } out_item_t;

  // Classification of one attribute pair.
  typedef struct packed {
    logic              skip;      // pair does not count
    logic              need_div;  // numeric pair with a nonzero range
    logic [DIST_W-1:0] sim;       // contribution when no division is needed
  } gda_eval_t;

  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] steps;
  } gda_div_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } gda_div_stat_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_CMP,
    S_NDIV,
    S_FIN,
    S_FDIV,
    S_OUT
  } gda_state_t;

endpackage

FILE: rtl/gda_eval.sv
// Classifies one attribute pair and forms the absolute difference of its values.
// Depends on gda_pkg.

module gda_eval (
  input  gda_pkg::in_item_t          item,
  output gda_pkg::gda_eval_t         ev,
  output logic [gda_pkg::VAL_W-1:0]  abs_diff
);

  logic signed [gda_pkg::VAL_W:0] diff;
  logic signed [gda_pkg::VAL_W:0] neg_diff;
  logic                           xa;
  logic                           ya;

  assign diff     = (gda_pkg::VAL_W + 1)'(item.x_value) - (gda_pkg::VAL_W + 1)'(item.y_value);
  assign neg_diff = -diff;
  assign abs_diff = diff[gda_pkg::VAL_W] ? neg_diff[gda_pkg::VAL_W-1:0]
                                         : diff[gda_pkg::VAL_W-1:0];

  // Any binary value other than one counts as zero.
  assign xa = (item.x_value == gda_pkg::VAL_W'(1));
  assign ya = (item.y_value == gda_pkg::VAL_W'(1));

  always_comb begin
    ev.skip     = 1'b0;
    ev.need_div = 1'b0;
    ev.sim      = '0;
    case (item.attr_kind)
      gda_pkg::KIND_NUMERIC: begin
        if (item.value_range == '0) begin
          ev.sim = gda_pkg::FX_ONE;
        end else begin
          ev.need_div = 1'b1;
        end
      end
      gda_pkg::KIND_NOMINAL: begin
        ev.sim = (item.x_value == item.y_value) ? gda_pkg::FX_ONE : '0;
      end
      gda_pkg::KIND_BINARY: begin
        if (xa && ya) begin
          ev.sim = gda_pkg::FX_ONE;
        end else if (!xa && !ya) begin
          ev.skip = 1'b1;
        end
      end
      default: begin
        ev.skip = 1'b1;
      end
    endcase
    if (item.x_missing || item.y_missing) begin
      ev.skip     = 1'b1;
      ev.need_div = 1'b0;
    end
  end

endmodule

FILE: rtl/gda_divider.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on gda_pkg; driven by the sequencer in the top level.

module gda_divider (
  input  logic                            clk,
  input  logic                            rst_n,
  input  gda_pkg::gda_div_cmd_t           cmd,
  input  logic [gda_pkg::VAL_W-1:0]       rem_init,
  input  logic [gda_pkg::SUM_W-1:0]       dvd_init,
  input  logic [gda_pkg::VAL_W-1:0]       divisor,
  output gda_pkg::gda_div_stat_t          stat,
  output logic [gda_pkg::SUM_W-1:0]       quotient
);

  logic [gda_pkg::VAL_W-1:0]  rem_r, rem_nxt;
  logic [gda_pkg::SUM_W-1:0]  dvd_r, dvd_nxt;
  logic [gda_pkg::SUM_W-1:0]  quo_r, quo_nxt;
  logic [gda_pkg::VAL_W-1:0]  div_r, div_nxt;
  logic [gda_pkg::STEP_W-1:0] cnt_r, cnt_nxt;
  logic                       busy_r, busy_nxt;
  logic                       done_r, done_nxt;

  logic [gda_pkg::VAL_W:0]    rem_sh;
  logic [gda_pkg::VAL_W:0]    rem_sub;
  logic                       ge;

  // One step: shift in the next dividend bit and subtract where it fits.
  assign rem_sh  = {rem_r, dvd_r[gda_pkg::SUM_W-1]};
  assign ge      = (rem_sh >= {1'b0, div_r});
  assign rem_sub = rem_sh - {1'b0, div_r};

  always_comb begin
    rem_nxt  = rem_r;
    dvd_nxt  = dvd_r;
    quo_nxt  = quo_r;
    div_nxt  = div_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (cmd.start) begin
      rem_nxt  = rem_init;
      dvd_nxt  = dvd_init;
      quo_nxt  = '0;
      div_nxt  = divisor;
      cnt_nxt  = cmd.steps;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = ge ? rem_sub[gda_pkg::VAL_W-1:0] : rem_sh[gda_pkg::VAL_W-1:0];
      dvd_nxt = {dvd_r[gda_pkg::SUM_W-2:0], 1'b0};
      quo_nxt = {quo_r[gda_pkg::SUM_W-2:0], ge};
      cnt_nxt = cnt_r - gda_pkg::STEP_W'(1);
      if (cnt_r == gda_pkg::STEP_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
    quo_r <= quo_nxt;
    div_r <= div_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = quo_r;

endmodule

FILE: rtl/gower_distance_accumulator_top.sv
// Top level of the Gower distance accumulator: sequencer, accumulators and result register.
// Depends on gda_pkg, gda_eval and gda_divider.
//
//   Channel  Ports                         Word
//   input    in_valid, in_stall, in_word   one attribute pair (in_item_t)
//   output   out_valid, out_stall, out_word distance and compared count (out_item_t)
//
// A nominal, binary, skipped or zero-range numeric pair is settled in evaluation alone.
// A numeric pair whose difference reaches its range clamps without dividing. Any other
// numeric pair waits on the bit-serial divider, which forms |x - y| / range. A word marked
// last adds the final mean, formed by the divider, or a distance of one when nothing was
// counted; either waits while an earlier result still blocks the result register.
// Reset is synchronous and active low; it clears the sequencer and both accumulators.
// in_stall is high whenever the sequencer is busy. A finished result moves to the result
// register and the sequencer returns to idle, so a stalled receiver only holds off the
// sender once a second result is ready while the first one still waits.

module gower_distance_accumulator_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  gda_pkg::in_item_t  in_word,
  output logic               out_valid,
  input  logic               out_stall,
  output gda_pkg::out_item_t out_word
);

  gda_pkg::gda_state_t              state_r, state_nxt;
  gda_pkg::in_item_t                item_r, item_nxt;
  logic [gda_pkg::VAL_W-1:0]        d_r, d_nxt;
  logic [gda_pkg::SUM_W-1:0]        sum_r, sum_nxt;
  logic [gda_pkg::CNT_W-1:0]        count_r, count_nxt;
  gda_pkg::out_item_t               out_word_r, out_word_nxt;
  logic                             out_valid_r, out_valid_nxt;

  gda_pkg::gda_eval_t               ev;
  logic [gda_pkg::VAL_W-1:0]        abs_diff;

  gda_pkg::gda_div_cmd_t            div_cmd;
  gda_pkg::gda_div_stat_t           div_stat;
  logic [gda_pkg::VAL_W-1:0]        div_rem_init;
  logic [gda_pkg::SUM_W-1:0]        div_dvd_init;
  logic [gda_pkg::VAL_W-1:0]        div_divisor;
  logic [gda_pkg::SUM_W-1:0]        div_quo;

  logic                             acc_en;
  logic [gda_pkg::DIST_W-1:0]       acc_val;
  logic                             acc_clr;
  gda_pkg::gda_state_t              after_acc;
  logic                             out_free;

  gda_eval u_eval (
    .item     (item_r),
    .ev       (ev),
    .abs_diff (abs_diff)
  );

  gda_divider u_divider (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (div_cmd),
    .rem_init (div_rem_init),
    .dvd_init (div_dvd_init),
    .divisor  (div_divisor),
    .stat     (div_stat),
    .quotient (div_quo)
  );

  assign in_stall  = (state_r != gda_pkg::S_IDLE);
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // The result register can take a new word when it is empty or is being read this cycle.
  assign out_free = !out_valid_r || !out_stall;

  // Once an attribute is folded in, a last word goes on to the final mean.
  assign after_acc = item_r.last_attr ? gda_pkg::S_FIN : gda_pkg::S_IDLE;

  // Sequencer.
  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    d_nxt         = d_r;
    out_word_nxt  = out_word_r;
    out_valid_nxt = out_valid_r;
    acc_en        = 1'b0;
    acc_val       = '0;
    acc_clr       = 1'b0;
    div_cmd.start = 1'b0;
    div_cmd.steps = gda_pkg::STEP_W'(gda_pkg::FRAC_BITS);
    div_rem_init  = d_r;
    div_dvd_init  = '0;
    div_divisor   = item_r.value_range;
    // A waiting result leaves the register when the receiver takes it.
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      gda_pkg::S_IDLE: begin
        if (in_valid) begin
          item_nxt  = in_word;
          state_nxt = gda_pkg::S_EVAL;
        end
      end
      gda_pkg::S_EVAL: begin
        if (ev.skip) begin
          state_nxt = after_acc;
        end else if (ev.need_div) begin
          d_nxt     = abs_diff;
          state_nxt = gda_pkg::S_CMP;
        end else begin
          acc_en    = 1'b1;
          acc_val   = ev.sim;
          state_nxt = after_acc;
        end
      end
      gda_pkg::S_CMP: begin
        // A difference at or beyond the range gives a quotient of at least one,
        // so the similarity clamps to zero without dividing.
        if (d_r >= item_r.value_range) begin
          acc_en    = 1'b1;
          state_nxt = after_acc;
        end else begin
          div_cmd.start = 1'b1;
          state_nxt     = gda_pkg::S_NDIV;
        end
      end
      gda_pkg::S_NDIV: begin
        if (div_stat.done) begin
          acc_en    = 1'b1;
          acc_val   = gda_pkg::FX_ONE - {1'b0, div_quo[gda_pkg::FRAC_BITS-1:0]};
          state_nxt = after_acc;
        end
      end
      gda_pkg::S_FIN: begin
        if (count_r == '0) begin
          // Nothing counted: the distance is one, once the result register is free.
          if (out_free) begin
            out_word_nxt.distance       = gda_pkg::FX_ONE;
            out_word_nxt.compared_count = count_r;
            out_valid_nxt               = 1'b1;
            acc_clr                     = 1'b1;
            state_nxt                   = gda_pkg::S_IDLE;
          end
        end else begin
          div_cmd.start = 1'b1;
          div_cmd.steps = gda_pkg::STEP_W'(gda_pkg::SUM_W);
          div_rem_init  = '0;
          div_dvd_init  = sum_r;
          div_divisor   = gda_pkg::VAL_W'(count_r);
          state_nxt     = gda_pkg::S_FDIV;
        end
      end
      gda_pkg::S_FDIV: begin
        // The mean never exceeds one, so its quotient fits in DIST_W bits.
        if (div_stat.done) begin
          if (out_free) begin
            out_word_nxt.distance       = gda_pkg::FX_ONE - div_quo[gda_pkg::DIST_W-1:0];
            out_word_nxt.compared_count = count_r;
            out_valid_nxt               = 1'b1;
            acc_clr                     = 1'b1;
            state_nxt                   = gda_pkg::S_IDLE;
          end else begin
            state_nxt = gda_pkg::S_OUT;
          end
        end
      end
      gda_pkg::S_OUT: begin
        // The divider holds its quotient while the earlier result is still waiting.
        if (out_free) begin
          out_word_nxt.distance       = gda_pkg::FX_ONE - div_quo[gda_pkg::DIST_W-1:0];
          out_word_nxt.compared_count = count_r;
          out_valid_nxt               = 1'b1;
          acc_clr                     = 1'b1;
          state_nxt                   = gda_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = gda_pkg::S_IDLE;
      end
    endcase
  end

  // Accumulators saturate once MAX_ATTRS attributes have been counted.
  always_comb begin
    sum_nxt   = sum_r;
    count_nxt = count_r;
    if (acc_clr) begin
      sum_nxt   = '0;
      count_nxt = '0;
    end else if (acc_en && (count_r < gda_pkg::CNT_W'(gda_pkg::MAX_ATTRS))) begin
      sum_nxt   = sum_r + gda_pkg::SUM_W'(acc_val);
      count_nxt = count_r + gda_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= gda_pkg::S_IDLE;
      sum_r       <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sum_r       <= sum_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    d_r        <= d_nxt;
    out_word_r <= out_word_nxt;
  end

  // A stalled result stays valid and unchanged until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_word)))
    else $error("stalled result changed");

  // The divider is never restarted while it is still stepping.
  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_cmd.start |-> !div_stat.busy)
    else $error("divider started while busy");

  // The divider only finishes while the sequencer waits on it.
  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.done |-> (state_r == gda_pkg::S_NDIV || state_r == gda_pkg::S_FDIV))
    else $error("divider finished while nobody waited");

  // The attribute count never passes its limit.
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= gda_pkg::CNT_W'(gda_pkg::MAX_ATTRS))
    else $error("attribute count past its limit");

  // An accepted word is evaluated in the next cycle.
  a_accept_eval: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == gda_pkg::S_EVAL))
    else $error("accepted word not evaluated");

endmodule
